// ===== rtl/core/bounded_list_engine_top_assert.svh =====
// Assertion macros for the bounded list engine top level.
`ifndef BOUNDED_LIST_ENGINE_TOP_ASSERT_SVH
`define BOUNDED_LIST_ENGINE_TOP_ASSERT_SVH

// Check that a condition implies a consequence in the same cycle.
`define BLE_ASSERT_SAME(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define BLE_ASSERT_NEXT(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/bleng_pkg.sv =====
// Shared constants, types and helpers for the bounded list engine.
package bleng_pkg;

  localparam int DEPTH    = 16;
  localparam int WORD_W   = 32;
  localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int FIDX_W   = 4;
  localparam int COUNT_W  = 5;
  localparam int OP_W     = 3;
  localparam int ST_W     = 2;

  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OP_W-1:0] OP_FIND       = 3'd4;
  localparam logic [OP_W-1:0] OP_REMOVE     = 3'd5;
  localparam logic [OP_W-1:0] OP_CLEAR      = 3'd6;
  localparam logic [OP_W-1:0] OP_SORT       = 3'd7;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  // read address sources
  localparam logic [1:0] RD_I    = 2'd0;
  localparam logic [1:0] RD_J    = 2'd1;
  localparam logic [1:0] RD_LAST = 2'd2;

  typedef struct packed {
    logic       capture;
    logic       refuse;
    logic       push_front;
    logic       push_back;
    logic       pop_finish;
    logic       clear;
    logic       scan_step;
    logic       scan_last;
    logic       sort_load;
    logic       sort_cmp;
    logic       sort_wr_best;
    logic       sort_wr_cur;
    logic [1:0] rd_src;
    logic       deliver;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            empty;
    logic            full;
    logic            one;
    logic            match;
    logic            last_i;
    logic            last_j;
    logic            last_sort;
  } stat_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] popped;
    logic                     found;
    logic [IDX_W-1:0]         fidx;
    logic [ST_W-1:0]          st;
    logic [CNT_W-1:0]         count;
  } res_t;

  // Logical position to physical slot in the circular store.
  function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] base,
                                                input logic [IDX_W-1:0] ofs);
    logic [IDX_W:0] s;
    s = {1'b0, base} + {1'b0, ofs};
    if (s >= (IDX_W+1)'(DEPTH)) begin
      s = s - (IDX_W+1)'(DEPTH);
    end
    return s[IDX_W-1:0];
  endfunction

endpackage

// ===== rtl/core/bounded_list_engine_top.sv =====
// Push, clear and refused words pass from accept through dispatch to the done state; pops
// add a read and a write-back state. Find and remove read and compare each entry visited
// through the single store read port. Sort is selection sort on that port.
// One word at a time: the next word is accepted once the result sits in the output register,
// even while stalled. Reset (rst, synchronous) empties the list and drops any pending result;
// stored words are not cleared, only the count and the head pointer.
`include "bounded_list_engine_top_assert.svh"

module bounded_list_engine_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [bleng_pkg::OP_W-1:0]          opcode,
  input  logic signed [bleng_pkg::WORD_W-1:0] operand,
  input  logic                                descending,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [bleng_pkg::WORD_W-1:0] popped_value,
  output logic                                found,
  output logic [bleng_pkg::FIDX_W-1:0]        found_index,
  output logic [bleng_pkg::ST_W-1:0]          status,
  output logic [bleng_pkg::COUNT_W-1:0]       count
);

  bleng_pkg::cmd_t  cmd;
  bleng_pkg::stat_t stat;
  bleng_pkg::res_t  res;
  logic             idle;
  logic             out_free;

  // The output register is free when empty or when its word leaves this cycle.
  assign out_free = !out_valid || !out_stall;

  // Take a new input word only while the sequencer waits in idle.
  assign in_stall = !idle;

  bleng_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .out_free (out_free),
    .stat     (stat),
    .cmd      (cmd),
    .idle     (idle)
  );

  bleng_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .opcode     (opcode),
    .operand    (operand),
    .descending (descending),
    .stat       (stat),
    .res        (res)
  );

  // Output register: load on deliver, drop valid once the word is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.deliver) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Payload holds while stalled; cast index and count to the port widths.
  always_ff @(posedge clk) begin
    if (cmd.deliver) begin
      popped_value <= res.popped;
      found        <= res.found;
      found_index  <= bleng_pkg::FIDX_W'(res.fidx);
      status       <= res.st;
      count        <= bleng_pkg::COUNT_W'(res.count);
    end
  end

  // The list never holds more entries than the store has slots.
  `BLE_ASSERT_SAME(a_count_bound, 1'b1, res.count <= bleng_pkg::CNT_W'(bleng_pkg::DEPTH), "count exceeds depth")
  // An accepted word keeps the input side stalled in the following cycle.
  `BLE_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "input not stalled after accept")
  // A result is only loaded when the output register can take it.
  `BLE_ASSERT_SAME(a_deliver_free, cmd.deliver, out_free, "result loaded over a stalled word")
  // Delivery only happens from a busy sequencer, never in idle.
  `BLE_ASSERT_SAME(a_deliver_busy, cmd.deliver, !idle, "result delivered while idle")

endmodule

// ===== rtl/core/bleng_ctrl.sv =====
// Sequencer for the bounded list engine: decodes the opcode and steps the datapath.
module bleng_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             out_free,
  input  bleng_pkg::stat_t stat,
  output bleng_pkg::cmd_t  cmd,
  output logic             idle
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_DISPATCH  = 4'd1;
  localparam logic [3:0] S_POP_RD    = 4'd2;
  localparam logic [3:0] S_POP_WB    = 4'd3;
  localparam logic [3:0] S_SCAN_RD   = 4'd4;
  localparam logic [3:0] S_SCAN_CMP  = 4'd5;
  localparam logic [3:0] S_SORT_RDI  = 4'd6;
  localparam logic [3:0] S_SORT_LDI  = 4'd7;
  localparam logic [3:0] S_SORT_RDJ  = 4'd8;
  localparam logic [3:0] S_SORT_CMPJ = 4'd9;
  localparam logic [3:0] S_SORT_SW1  = 4'd10;
  localparam logic [3:0] S_SORT_SW2  = 4'd11;
  localparam logic [3:0] S_DONE      = 4'd12;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign idle = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.rd_src = bleng_pkg::RD_I;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        cmd.capture = in_valid;
        if (in_valid) begin
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_next = S_DONE;
        unique case (stat.op) inside
          bleng_pkg::OP_PUSH_FRONT: begin
            cmd.refuse     = stat.full;
            cmd.push_front = !stat.full;
          end
          bleng_pkg::OP_PUSH_BACK: begin
            cmd.refuse    = stat.full;
            cmd.push_back = !stat.full;
          end
          bleng_pkg::OP_POP_FRONT, bleng_pkg::OP_POP_BACK: begin
            cmd.refuse = stat.empty;
            if (!stat.empty) begin
              state_next = S_POP_RD;
            end
          end
          bleng_pkg::OP_FIND, bleng_pkg::OP_REMOVE: begin
            cmd.refuse = stat.empty;
            if (!stat.empty) begin
              state_next = S_SCAN_RD;
            end
          end
          bleng_pkg::OP_CLEAR: begin
            cmd.clear = 1'b1;
          end
          default: begin
            cmd.refuse = stat.empty;
            if (!stat.empty && !stat.one) begin
              state_next = S_SORT_RDI;
            end
          end
        endcase
      end
      S_POP_RD: begin
        cmd.rd_src = (stat.op == bleng_pkg::OP_POP_FRONT) ? bleng_pkg::RD_I
                                                           : bleng_pkg::RD_LAST;
        state_next = S_POP_WB;
      end
      S_POP_WB: begin
        cmd.pop_finish = 1'b1;
        state_next     = S_DONE;
      end
      S_SCAN_RD: begin
        cmd.rd_src = bleng_pkg::RD_I;
        state_next = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        cmd.scan_step = 1'b1;
        cmd.scan_last = stat.last_i || ((stat.op == bleng_pkg::OP_FIND) && stat.match);
        state_next    = cmd.scan_last ? S_DONE : S_SCAN_RD;
      end
      S_SORT_RDI: begin
        cmd.rd_src = bleng_pkg::RD_I;
        state_next = S_SORT_LDI;
      end
      S_SORT_LDI: begin
        cmd.sort_load = 1'b1;
        state_next    = S_SORT_RDJ;
      end
      S_SORT_RDJ: begin
        cmd.rd_src = bleng_pkg::RD_J;
        state_next = S_SORT_CMPJ;
      end
      S_SORT_CMPJ: begin
        cmd.sort_cmp = 1'b1;
        state_next   = stat.last_j ? S_SORT_SW1 : S_SORT_RDJ;
      end
      S_SORT_SW1: begin
        cmd.sort_wr_best = 1'b1;
        state_next       = S_SORT_SW2;
      end
      S_SORT_SW2: begin
        cmd.sort_wr_cur = 1'b1;
        state_next      = stat.last_sort ? S_DONE : S_SORT_RDI;
      end
      S_DONE: begin
        cmd.deliver = out_free;
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/bleng_dp.sv =====
// Datapath of the bounded list engine: circular word store, count, scan and sort registers.
module bleng_dp (
  input  logic                                    clk,
  input  logic                                    rst,
  input  bleng_pkg::cmd_t                         cmd,
  input  logic [bleng_pkg::OP_W-1:0]              opcode,
  input  logic signed [bleng_pkg::WORD_W-1:0]     operand,
  input  logic                                    descending,
  output bleng_pkg::stat_t                        stat,
  output bleng_pkg::res_t                         res
);

  logic signed [bleng_pkg::WORD_W-1:0] mem [bleng_pkg::DEPTH];
  logic signed [bleng_pkg::WORD_W-1:0] rd_data;

  logic [bleng_pkg::IDX_W-1:0]  head;
  logic [bleng_pkg::CNT_W-1:0]  cnt;
  logic [bleng_pkg::CNT_W-1:0]  i;
  logic [bleng_pkg::CNT_W-1:0]  j;
  logic [bleng_pkg::CNT_W-1:0]  k;
  logic [bleng_pkg::IDX_W-1:0]  bidx;
  logic signed [bleng_pkg::WORD_W-1:0] best;
  logic signed [bleng_pkg::WORD_W-1:0] cur;
  logic [bleng_pkg::OP_W-1:0]   op;
  logic signed [bleng_pkg::WORD_W-1:0] val;
  logic                         desc;
  logic signed [bleng_pkg::WORD_W-1:0] popped;
  logic                         found;
  logic [bleng_pkg::IDX_W-1:0]  fidx;
  logic [bleng_pkg::ST_W-1:0]   st;

  logic [bleng_pkg::IDX_W-1:0]  head_dec;
  logic [bleng_pkg::CNT_W-1:0]  last_pos;
  logic [bleng_pkg::IDX_W-1:0]  rd_phys;
  logic                         wr_en;
  logic [bleng_pkg::IDX_W-1:0]  wr_phys;
  logic signed [bleng_pkg::WORD_W-1:0] wr_data;
  logic                         keep;
  logic                         better;
  logic                         is_push;
  logic                         is_pop;

  assign head_dec = (head == '0) ? bleng_pkg::IDX_W'(bleng_pkg::DEPTH - 1)
                                 : head - bleng_pkg::IDX_W'(1);
  assign last_pos = cnt - bleng_pkg::CNT_W'(1);
  assign keep     = (rd_data != val);
  assign better   = desc ? (rd_data > best) : (rd_data < best);
  assign is_push  = (op == bleng_pkg::OP_PUSH_FRONT) || (op == bleng_pkg::OP_PUSH_BACK);
  assign is_pop   = (op == bleng_pkg::OP_POP_FRONT) || (op == bleng_pkg::OP_POP_BACK);

  always_comb begin
    case (cmd.rd_src)
      bleng_pkg::RD_J:    rd_phys = bleng_pkg::wrap_add(head, j[bleng_pkg::IDX_W-1:0]);
      bleng_pkg::RD_LAST: rd_phys = bleng_pkg::wrap_add(head, last_pos[bleng_pkg::IDX_W-1:0]);
      default:            rd_phys = bleng_pkg::wrap_add(head, i[bleng_pkg::IDX_W-1:0]);
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_phys = head;
    wr_data = val;
    if (cmd.push_front) begin
      wr_en   = 1'b1;
      wr_phys = head_dec;
    end else if (cmd.push_back) begin
      wr_en   = 1'b1;
      wr_phys = bleng_pkg::wrap_add(head, cnt[bleng_pkg::IDX_W-1:0]);
    end else if (cmd.scan_step && (op == bleng_pkg::OP_REMOVE) && keep) begin
      wr_en   = 1'b1;
      wr_phys = bleng_pkg::wrap_add(head, k[bleng_pkg::IDX_W-1:0]);
      wr_data = rd_data;
    end else if (cmd.sort_wr_best) begin
      wr_en   = 1'b1;
      wr_phys = bleng_pkg::wrap_add(head, i[bleng_pkg::IDX_W-1:0]);
      wr_data = best;
    end else if (cmd.sort_wr_cur) begin
      wr_en   = 1'b1;
      wr_phys = bleng_pkg::wrap_add(head, bidx);
      wr_data = cur;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_phys] <= wr_data;
    end
    rd_data <= mem[rd_phys];
  end

  // head and count are control state
  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      cnt  <= '0;
    end else begin
      if (cmd.push_front) begin
        head <= head_dec;
        cnt  <= cnt + bleng_pkg::CNT_W'(1);
      end else if (cmd.push_back) begin
        cnt <= cnt + bleng_pkg::CNT_W'(1);
      end else if (cmd.pop_finish) begin
        if (op == bleng_pkg::OP_POP_FRONT) begin
          head <= bleng_pkg::wrap_add(head, bleng_pkg::IDX_W'(1));
        end
        cnt <= last_pos;
      end else if (cmd.clear) begin
        cnt <= '0;
      end else if (cmd.scan_step && cmd.scan_last && (op == bleng_pkg::OP_REMOVE)) begin
        cnt <= keep ? k + bleng_pkg::CNT_W'(1) : k;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op     <= opcode;
      val    <= operand;
      desc   <= descending;
      popped <= '0;
      found  <= 1'b0;
      fidx   <= '0;
      st     <= bleng_pkg::ST_OK;
      i      <= '0;
      k      <= '0;
    end
    if (cmd.refuse) begin
      st <= is_push ? bleng_pkg::ST_FULL : bleng_pkg::ST_EMPTY;
      if (is_pop) begin
        popped <= '1;
      end
    end
    if (cmd.pop_finish) begin
      popped <= rd_data;
    end
    if (cmd.scan_step) begin
      i <= i + bleng_pkg::CNT_W'(1);
      if ((op == bleng_pkg::OP_FIND) && !keep && !found) begin
        found <= 1'b1;
        fidx  <= i[bleng_pkg::IDX_W-1:0];
      end
      if ((op == bleng_pkg::OP_REMOVE) && keep) begin
        k <= k + bleng_pkg::CNT_W'(1);
      end
    end
    if (cmd.sort_load) begin
      best <= rd_data;
      cur  <= rd_data;
      bidx <= i[bleng_pkg::IDX_W-1:0];
      j    <= i + bleng_pkg::CNT_W'(1);
    end
    if (cmd.sort_cmp) begin
      j <= j + bleng_pkg::CNT_W'(1);
      if (better) begin
        best <= rd_data;
        bidx <= j[bleng_pkg::IDX_W-1:0];
      end
    end
    if (cmd.sort_wr_cur) begin
      i <= i + bleng_pkg::CNT_W'(1);
    end
  end

  assign stat.op        = op;
  assign stat.empty     = (cnt == '0);
  assign stat.full      = (cnt == bleng_pkg::CNT_W'(bleng_pkg::DEPTH));
  assign stat.one       = (cnt == bleng_pkg::CNT_W'(1));
  assign stat.match     = !keep;
  assign stat.last_i    = ((i + bleng_pkg::CNT_W'(1)) == cnt);
  assign stat.last_j    = ((j + bleng_pkg::CNT_W'(1)) == cnt);
  assign stat.last_sort = ((i + bleng_pkg::CNT_W'(2)) == cnt);

  assign res.popped = popped;
  assign res.found  = found;
  assign res.fidx   = fidx;
  assign res.st     = st;
  assign res.count  = cnt;

endmodule
